@@ sv/point_mass_gravity_source_top_assert.svh @@
// ----------------------------------------------------------------------------
// point mass gravity source: assertion macros
// shared check forms used by the rtl of the gravity source block
// ----------------------------------------------------------------------------
`ifndef POINT_MASS_GRAVITY_SOURCE_TOP_ASSERT_SVH
`define POINT_MASS_GRAVITY_SOURCE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PMS_ASSERT_HOLDS(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("pms check failed");

// next-cycle implication, checked out of reset
`define PMS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("pms check failed");

`endif

@@ sv/pms_pkg.sv @@
// ----------------------------------------------------------------------------
// pms_pkg
// widths, register codes, pipeline context type and saturation helper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

    localparam int W       = 32;
    localparam int AD_W    = 33;           // |pos - center|
    localparam int SQ_W    = 66;           // squared offsets, sum of squares
    localparam int ROOT_W  = 33;           // integer root
    localparam int R3_W    = 99;           // root cubed
    localparam int KD_W    = 64;           // coefficient times offset
    localparam int Q_W     = 63;           // quotient bits, top one flags overflow
    localparam int G_W     = 62;           // clipped acceleration magnitude
    localparam int ACC_W   = 97;           // signed v.g accumulator
    localparam int MUL_W   = 64;
    localparam int HALF_W  = 32;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_COEF = 2'd3;

    localparam logic [G_W-1:0] G_MAX = '1;

    typedef struct packed {
        logic                zero;
        logic [2:0]          gneg;
        logic [2:0][W-1:0]   vel;
        logic [MUL_W-1:0]    p;
    } t_ctx;

    function automatic logic [W-1:0] sat32(input logic [2*MUL_W-1:0] m, input logic neg);
        logic [W-1:0] res;
        if (!neg) begin
            res = (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[W-1:0];
        end else begin
            res = (m > 128'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[W-1:0]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/pms_if.sv @@
// ----------------------------------------------------------------------------
// pms_if
// valid/ready channels for cells in and sources out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pms_cell_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [31:0] density;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [31:0] cell_volume;

    modport source (output valid, pos_x, pos_y, pos_z, density, vel_x, vel_y, vel_z,
                    cell_volume, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, density, vel_x, vel_y, vel_z,
                    cell_volume, output ready);
endinterface

interface pms_src_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] mom_source_x;
    logic signed [31:0] mom_source_y;
    logic signed [31:0] mom_source_z;
    logic signed [31:0] energy_source;
    logic        zero_distance;

    modport source (output valid, mom_source_x, mom_source_y, mom_source_z, energy_source,
                    zero_distance, input ready);
    modport sink   (input valid, mom_source_x, mom_source_y, mom_source_z, energy_source,
                    zero_distance, output ready);
endinterface

`default_nettype wire

@@ sv/pms_mul64.sv @@
// ----------------------------------------------------------------------------
// pms_mul64
// 64x64 unsigned multiply in two stages: 32x32 partial products, then sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pms_mul64 import pms_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [MUL_W-1:0]     i_a,
    input  logic [MUL_W-1:0]     i_b,
    output logic [2*MUL_W-1:0]   o_p
);

    logic [3:0][MUL_W-1:0] r_pp;
    logic [2*MUL_W-1:0]    r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp[0] <= MUL_W'(i_a[HALF_W-1:0])     * MUL_W'(i_b[HALF_W-1:0]);
            r_pp[1] <= MUL_W'(i_a[HALF_W-1:0])     * MUL_W'(i_b[MUL_W-1:HALF_W]);
            r_pp[2] <= MUL_W'(i_a[MUL_W-1:HALF_W]) * MUL_W'(i_b[HALF_W-1:0]);
            r_pp[3] <= MUL_W'(i_a[MUL_W-1:HALF_W]) * MUL_W'(i_b[MUL_W-1:HALF_W]);
            r_p     <= (2*MUL_W)'(r_pp[0])
                     + ((2*MUL_W)'(r_pp[1]) << HALF_W)
                     + ((2*MUL_W)'(r_pp[2]) << HALF_W)
                     + ((2*MUL_W)'(r_pp[3]) << MUL_W);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ sv/point_mass_gravity_source_top.sv @@
// Point mass gravity source: takes one cell per clock while the output is not
// stalled, and returns its momentum sources rho*g*vol and energy source
// rho*(v.g)*vol, with g = -k*d/|d|^3 about the configured centre. Most of the
// pipeline is the square root (one root bit per stage, 33 stages) and the divide
// (one quotient bit per stage, 63 stages); every stage holds while the output
// is stalled. A cell on the centre gives zero sources with zero_distance set.
// Write the centre and coefficient only while no cell is in flight.
// ----------------------------------------------------------------------------
// point_mass_gravity_source_top
// pipelined point mass gravity source term, fixed point, saturated results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "point_mass_gravity_source_top_assert.svh"

module point_mass_gravity_source_top import pms_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pms_cell_if.sink             i_cell,
    pms_src_if.source            o_src,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [W-1:0]         i_cfg_data
);

    localparam int NUM_W = KD_W + 2 * FRAC_BITS;
    localparam int CMP_W = (NUM_W > R3_W) ? NUM_W : R3_W;
    localparam int NSQ   = ROOT_W;
    localparam int NDV   = Q_W;

    // configuration
    logic [2:0][W-1:0] r_center;
    logic [W-1:0]      r_gcoef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_gcoef  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X:  r_center[0] <= i_cfg_data;
                CFG_CENTER_Y:  r_center[1] <= i_cfg_data;
                CFG_CENTER_Z:  r_center[2] <= i_cfg_data;
                CFG_GRAV_COEF: r_gcoef     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    logic r_out_valid;
    assign adv = !r_out_valid || o_src.ready;
    assign i_cell.ready = adv;

    // stage 1: offsets
    logic [2:0][W-1:0]    pos_in, vel_in;
    logic [2:0][AD_W-1:0] n_d, n_s1_ad;
    logic [2:0]           n_s1_gneg;

    assign pos_in = {i_cell.pos_z, i_cell.pos_y, i_cell.pos_x};
    assign vel_in = {i_cell.vel_z, i_cell.vel_y, i_cell.vel_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i] = {pos_in[i][W-1], pos_in[i]} - {r_center[i][W-1], r_center[i]};
            n_s1_ad[i] = n_d[i][AD_W-1] ? (AD_W'(0) - n_d[i]) : n_d[i];
            n_s1_gneg[i] = !n_d[i][AD_W-1] && (n_d[i] != '0);
        end
    end

    logic                 r_s1_valid;
    logic [2:0][AD_W-1:0] r_s1_ad;
    logic [2:0]           r_s1_gneg;
    logic [2:0][W-1:0]    r_s1_vel;
    logic [W-1:0]         r_s1_rho, r_s1_vol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ad   <= n_s1_ad;
            r_s1_gneg <= n_s1_gneg;
            r_s1_vel  <= vel_in;
            r_s1_rho  <= i_cell.density;
            r_s1_vol  <= i_cell.cell_volume;
        end
    end

    // stage 2: squares, k*|d|, rho*vol
    logic                 r_s2_valid;
    logic [2:0][SQ_W-1:0] r_s2_sq;
    logic [2:0][KD_W-1:0] r_s2_kd;
    logic [MUL_W-1:0]     r_s2_pf;
    logic                 r_s2_zero;
    logic [2:0]           r_s2_gneg;
    logic [2:0][W-1:0]    r_s2_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_sq[i] <= SQ_W'(r_s1_ad[i]) * SQ_W'(r_s1_ad[i]);
                r_s2_kd[i] <= KD_W'(r_gcoef) * KD_W'(r_s1_ad[i]);
            end
            r_s2_pf   <= MUL_W'(r_s1_rho) * MUL_W'(r_s1_vol);
            r_s2_zero <= (r_s1_ad == '0);
            r_s2_gneg <= r_s1_gneg;
            r_s2_vel  <= r_s1_vel;
        end
    end

    // stage 3: r^2 and p
    logic                 r_s3_valid;
    logic [SQ_W-1:0]      r_s3_r2;
    logic [2:0][KD_W-1:0] r_s3_kd;
    t_ctx                 r_s3_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_r2       <= r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
            r_s3_kd       <= r_s2_kd;
            r_s3_ctx.zero <= r_s2_zero;
            r_s3_ctx.gneg <= r_s2_gneg;
            r_s3_ctx.vel  <= r_s2_vel;
            r_s3_ctx.p    <= r_s2_pf >> FRAC_BITS;
        end
    end

    // square root, one result bit per stage
    logic [NSQ:0]                 w_sr_valid;
    logic [ROOT_W-1:0]            w_sr_res [NSQ+1];
    logic [SQ_W-1:0]              w_sr_rem [NSQ+1];
    logic [2:0][KD_W-1:0]         w_sr_kd  [NSQ+1];
    t_ctx                         w_sr_ctx [NSQ+1];

    assign w_sr_valid[0] = r_s3_valid;
    assign w_sr_res[0]   = '0;
    assign w_sr_rem[0]   = r_s3_r2;
    assign w_sr_kd[0]    = r_s3_kd;
    assign w_sr_ctx[0]   = r_s3_ctx;

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        localparam int B = NSQ - 1 - k;
        logic [SQ_W:0]        trial;
        logic                 take;
        logic                 r_valid;
        logic [ROOT_W-1:0]    r_res;
        logic [SQ_W-1:0]      r_rem;
        logic [2:0][KD_W-1:0] r_kd;
        t_ctx                 r_ctx;

        // (2*res + 2^b) * 2^b against the remaining radicand
        assign trial = ((SQ_W+1)'(w_sr_res[k]) << (B + 1)) | ((SQ_W+1)'(1) << (2 * B));
        assign take  = ({1'b0, w_sr_rem[k]} >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (adv) begin
                r_valid <= w_sr_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rem <= take ? (w_sr_rem[k] - trial[SQ_W-1:0]) : w_sr_rem[k];
                r_res <= take ? (w_sr_res[k] | (ROOT_W'(1) << B)) : w_sr_res[k];
                r_kd  <= w_sr_kd[k];
                r_ctx <= w_sr_ctx[k];
            end
        end

        assign w_sr_valid[k+1] = r_valid;
        assign w_sr_res[k+1]   = r_res;
        assign w_sr_rem[k+1]   = r_rem;
        assign w_sr_kd[k+1]    = r_kd;
        assign w_sr_ctx[k+1]   = r_ctx;
    end

    // r^3 over three stages
    logic                 r_ra_valid, r_rb_valid, r_rc_valid;
    logic [SQ_W-1:0]      r_ra_rr;
    logic [ROOT_W-1:0]    r_ra_root;
    logic [SQ_W-1:0]      r_rb_ma, r_rb_mb;
    logic [R3_W-1:0]      r_rc_r3;
    logic [2:0][KD_W-1:0] r_ra_kd, r_rb_kd, r_rc_kd;
    t_ctx                 r_ra_ctx, r_rb_ctx, r_rc_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra_valid <= 1'b0;
            r_rb_valid <= 1'b0;
            r_rc_valid <= 1'b0;
        end else if (adv) begin
            r_ra_valid <= w_sr_valid[NSQ];
            r_rb_valid <= r_ra_valid;
            r_rc_valid <= r_rb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ra_rr   <= SQ_W'(w_sr_res[NSQ]) * SQ_W'(w_sr_res[NSQ]);
            r_ra_root <= w_sr_res[NSQ];
            r_ra_kd   <= w_sr_kd[NSQ];
            r_ra_ctx  <= w_sr_ctx[NSQ];
            r_rb_ma   <= SQ_W'(r_ra_rr[ROOT_W-1:0]) * SQ_W'(r_ra_root);
            r_rb_mb   <= SQ_W'(r_ra_rr[SQ_W-1:ROOT_W]) * SQ_W'(r_ra_root);
            r_rb_kd   <= r_ra_kd;
            r_rb_ctx  <= r_ra_ctx;
            r_rc_r3   <= R3_W'(r_rb_ma) + (R3_W'(r_rb_mb) << ROOT_W);
            r_rc_kd   <= r_rb_kd;
            r_rc_ctx  <= r_rb_ctx;
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    logic [NDV:0]              w_dv_valid;
    logic [2:0][NUM_W-1:0]     w_dv_rem [NDV+1];
    logic [2:0][Q_W-1:0]       w_dv_q   [NDV+1];
    logic [R3_W-1:0]           w_dv_r3  [NDV+1];
    t_ctx                      w_dv_ctx [NDV+1];

    assign w_dv_valid[0] = r_rc_valid;
    assign w_dv_q[0]     = '0;
    assign w_dv_r3[0]    = r_rc_r3;
    assign w_dv_ctx[0]   = r_rc_ctx;
    assign w_dv_rem[0]   = {{r_rc_kd[2], {(2 * FRAC_BITS){1'b0}}},
                            {r_rc_kd[1], {(2 * FRAC_BITS){1'b0}}},
                            {r_rc_kd[0], {(2 * FRAC_BITS){1'b0}}}};

    for (genvar k = 0; k < NDV; k++) begin : g_div
        localparam int B = NDV - 1 - k;
        logic [CMP_W-1:0]      dvs;
        logic [2:0][NUM_W-1:0] n_rem;
        logic [2:0][Q_W-1:0]   n_q;
        logic                  r_valid;
        logic [2:0][NUM_W-1:0] r_rem;
        logic [2:0][Q_W-1:0]   r_q;
        logic [R3_W-1:0]       r_dv;
        t_ctx                  r_ctx;

        assign dvs = CMP_W'(w_dv_r3[k]) << B;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                if ((CMP_W'(w_dv_rem[k][i]) >> B) >= CMP_W'(w_dv_r3[k])) begin
                    n_rem[i] = w_dv_rem[k][i] - dvs[NUM_W-1:0];
                    n_q[i]   = w_dv_q[k][i] | (Q_W'(1) << B);
                end else begin
                    n_rem[i] = w_dv_rem[k][i];
                    n_q[i]   = w_dv_q[k][i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (adv) begin
                r_valid <= w_dv_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_dv  <= w_dv_r3[k];
                r_ctx <= w_dv_ctx[k];
            end
        end

        assign w_dv_valid[k+1] = r_valid;
        assign w_dv_rem[k+1]   = r_rem;
        assign w_dv_q[k+1]     = r_q;
        assign w_dv_r3[k+1]    = r_dv;
        assign w_dv_ctx[k+1]   = r_ctx;
    end

    // |g| with clip, then p*|g| and |v|*|g|
    logic [2:0][G_W-1:0]       gm;
    logic [2:0][W-1:0]         av;
    logic [2:0]                tneg;
    logic [2:0][2*MUL_W-1:0]   mom_prod, vg_prod;
    t_ctx                      dv_ctx;

    assign dv_ctx = w_dv_ctx[NDV];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            gm[i]   = w_dv_q[NDV][i][Q_W-1] ? G_MAX : w_dv_q[NDV][i][G_W-1:0];
            av[i]   = dv_ctx.vel[i][W-1] ? (W'(0) - dv_ctx.vel[i]) : dv_ctx.vel[i];
            tneg[i] = dv_ctx.vel[i][W-1] != dv_ctx.gneg[i];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane_mul
        pms_mul64 u_mom (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_a   (dv_ctx.p),
            .i_b   (MUL_W'(gm[i])),
            .o_p   (mom_prod[i])
        );
        pms_mul64 u_vg (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_a   (MUL_W'(av[i])),
            .i_b   (MUL_W'(gm[i])),
            .o_p   (vg_prod[i])
        );
    end

    logic [1:0] r_mu_valid;
    t_ctx       r_mu_ctx  [2];
    logic [2:0] r_mu_tneg [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_valid <= '0;
        end else if (adv) begin
            r_mu_valid <= {r_mu_valid[0], w_dv_valid[NDV]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mu_ctx[0]  <= dv_ctx;
            r_mu_ctx[1]  <= r_mu_ctx[0];
            r_mu_tneg[0] <= tneg;
            r_mu_tneg[1] <= r_mu_tneg[0];
        end
    end

    // momentum results and signed v.g sum
    logic [2:0][W-1:0] n_e1_mom;
    logic [ACC_W-1:0]  n_e1_acc;

    always_comb begin
        n_e1_acc = '0;
        for (int i = 0; i < 3; i++) begin
            n_e1_mom[i] = sat32(mom_prod[i] >> FRAC_BITS, r_mu_ctx[1].gneg[i]);
            if (r_mu_tneg[1][i]) begin
                n_e1_acc = n_e1_acc - vg_prod[i][ACC_W-1:0];
            end else begin
                n_e1_acc = n_e1_acc + vg_prod[i][ACC_W-1:0];
            end
        end
    end

    logic              r_e1_valid, r_e2_valid;
    logic [2:0][W-1:0] r_e1_mom, r_e2_mom;
    logic [ACC_W-1:0]  r_e1_acc;
    t_ctx              r_e1_ctx, r_e2_ctx;
    logic [G_W-1:0]    r_e2_vgm;
    logic              r_e2_vneg;
    logic [ACC_W-1:0]  e2_mag, e2_sh;

    assign e2_mag = r_e1_acc[ACC_W-1] ? (ACC_W'(0) - r_e1_acc) : r_e1_acc;
    assign e2_sh  = e2_mag >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_valid <= 1'b0;
            r_e2_valid <= 1'b0;
        end else if (adv) begin
            r_e1_valid <= r_mu_valid[1];
            r_e2_valid <= r_e1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e1_mom  <= n_e1_mom;
            r_e1_acc  <= n_e1_acc;
            r_e1_ctx  <= r_mu_ctx[1];
            r_e2_mom  <= r_e1_mom;
            r_e2_ctx  <= r_e1_ctx;
            r_e2_vneg <= r_e1_acc[ACC_W-1];
            r_e2_vgm  <= (e2_sh > ACC_W'(G_MAX)) ? G_MAX : e2_sh[G_W-1:0];
        end
    end

    // p * |v.g|
    logic [2*MUL_W-1:0] en_prod;

    pms_mul64 u_energy (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_e2_ctx.p),
        .i_b   (MUL_W'(r_e2_vgm)),
        .o_p   (en_prod)
    );

    logic [1:0]        r_m2_valid;
    logic [2:0][W-1:0] r_m2_mom  [2];
    logic [1:0]        r_m2_vneg;
    logic [1:0]        r_m2_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= '0;
        end else if (adv) begin
            r_m2_valid <= {r_m2_valid[0], r_e2_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m2_mom[0] <= r_e2_mom;
            r_m2_mom[1] <= r_m2_mom[0];
            r_m2_vneg   <= {r_m2_vneg[0], r_e2_vneg};
            r_m2_zero   <= {r_m2_zero[0], r_e2_ctx.zero};
        end
    end

    // output register
    logic [2:0][W-1:0] r_out_mom;
    logic [W-1:0]      r_out_energy;
    logic              r_out_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_m2_valid[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_zero <= r_m2_zero[1];
            if (r_m2_zero[1]) begin
                r_out_mom    <= '0;
                r_out_energy <= '0;
            end else begin
                r_out_mom    <= r_m2_mom[1];
                r_out_energy <= sat32(en_prod >> FRAC_BITS, r_m2_vneg[1]);
            end
        end
    end

    assign o_src.valid         = r_out_valid;
    assign o_src.mom_source_x  = r_out_mom[0];
    assign o_src.mom_source_y  = r_out_mom[1];
    assign o_src.mom_source_z  = r_out_mom[2];
    assign o_src.energy_source = r_out_energy;
    assign o_src.zero_distance = r_out_zero;

    `PMS_ASSERT_HOLDS(a_zero_cell_no_source, r_out_valid && r_out_zero, (r_out_mom == '0) && (r_out_energy == '0))
    `PMS_ASSERT_NEXT(a_zero_detect, adv && r_s1_valid && (r_s1_ad == '0), r_s2_zero)
    `PMS_ASSERT_HOLDS(a_root_nonzero, w_sr_valid[NSQ] && !w_sr_ctx[NSQ].zero, w_sr_res[NSQ] != '0)
    `PMS_ASSERT_NEXT(a_stall_freezes_root, !adv, $stable(w_sr_valid))

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// gravity source testbench: directed table then random cells, scoreboarded
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top import pms_pkg::*;;

    localparam int FB = 16;
    localparam int LATENCY = 109;
    localparam logic [61:0] GCLIP = {62{1'b1}};
    localparam int N_RANDOM = 850;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic [31:0]        rho;
        logic signed [31:0] vx, vy, vz;
        logic [31:0]        vol;
    } t_cell;

    typedef struct {
        logic [31:0] mx, my, mz, en;
        logic        zd;
    } t_src;

    typedef struct {
        t_cell c;
        logic  known;
        t_src  r;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_CENTER_X;
    logic [W-1:0] i_cfg_data = '0;

    pms_cell_if cell_ch ();
    pms_src_if  src_ch ();

    point_mass_gravity_source_top #(.FRAC_BITS(FB)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cell     (cell_ch.sink),
        .o_src      (src_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic signed [31:0] cen_x, cen_y, cen_z;
    logic [31:0] coeff;
    t_src pending_src[$];
    int errors = 0;
    longint cycles = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic logic [31:0] clamp32(input logic [127:0] m, input logic negv);
        if (!negv) return (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        return (m > 128'h8000_0000) ? 32'h8000_0000 : 32'd0 - m[31:0];
    endfunction

    function automatic t_src gravity_sources(input t_cell c);
        t_src s;
        logic signed [33:0] d[3];
        logic [32:0] ad[3];
        logic gn[3];
        logic [127:0] r2, r3, num, q, prod;
        logic [63:0] root, p, cand;
        logic [61:0] gm[3];
        logic signed [130:0] acc;
        logic [130:0] mag;
        logic signed [32:0] v;
        logic [32:0] av;
        logic vn;
        logic [61:0] vgm;
        d[0] = 34'(c.px) - 34'(cen_x);
        d[1] = 34'(c.py) - 34'(cen_y);
        d[2] = 34'(c.pz) - 34'(cen_z);
        r2 = 0;
        for (int i = 0; i < 3; i++) begin
            ad[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
            gn[i] = d[i] > 0;
            r2 += 128'(ad[i]) * 128'(ad[i]);
        end
        s = '{default: '0};
        if (r2 == 0) begin
            s.zd = 1'b1;
            return s;
        end
        root = 0;
        for (int b = 34; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= r2) root = cand;
        end
        r3 = 128'(root) * 128'(root) * 128'(root);
        p = 64'((128'(c.rho) * 128'(c.vol)) >> FB);
        for (int i = 0; i < 3; i++) begin
            num = (128'(coeff) * 128'(ad[i])) << (2 * FB);
            q = num / r3;
            gm[i] = (q > 128'(GCLIP)) ? GCLIP : q[61:0];
            prod = (128'(p) * 128'(gm[i])) >> FB;
            case (i)
                0: s.mx = clamp32(prod, gn[i]);
                1: s.my = clamp32(prod, gn[i]);
                default: s.mz = clamp32(prod, gn[i]);
            endcase
        end
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            v = (i == 0) ? 33'(c.vx) : (i == 1) ? 33'(c.vy) : 33'(c.vz);
            av = v < 0 ? 33'(-v) : 33'(v);
            if ((v < 0) != gn[i]) acc -= 131'(av) * 131'(gm[i]);
            else acc += 131'(av) * 131'(gm[i]);
        end
        vn = acc < 0;
        mag = vn ? 131'(-acc) : 131'(acc);
        mag = mag >> FB;
        vgm = (mag > 131'(GCLIP)) ? GCLIP : mag[61:0];
        s.en = clamp32((128'(p) * 128'(vgm)) >> FB, vn);
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_CENTER_X: cen_x = val;
            CFG_CENTER_Y: cen_y = val;
            CFG_CENTER_Z: cen_z = val;
            default:      coeff = val;
        endcase
    endtask

    task automatic set_centre(input logic [31:0] x, y, z, k);
        write_reg(CFG_CENTER_X, x);
        write_reg(CFG_CENTER_Y, y);
        write_reg(CFG_CENTER_Z, z);
        write_reg(CFG_GRAV_COEF, k);
    endtask

    task automatic drain();
        wait (pending_src.size() == 0);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic send_cell(input t_cell c, input logic known, input t_src want);
        t_src e;
        repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10)) @(negedge i_clk);
        e = known ? want : gravity_sources(c);
        cell_ch.valid = 1'b1;
        cell_ch.pos_x = c.px; cell_ch.pos_y = c.py; cell_ch.pos_z = c.pz;
        cell_ch.density = c.rho;
        cell_ch.vel_x = c.vx; cell_ch.vel_y = c.vy; cell_ch.vel_z = c.vz;
        cell_ch.cell_volume = c.vol;
        @(posedge i_clk);
        while (!cell_ch.ready) @(posedge i_clk);
        pending_src.push_back(e);
        @(negedge i_clk);
        cell_ch.valid = 1'b0;
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 255) << FB;
            3: return 32'($signed($urandom_range(0, 4096)) - 2048) <<< FB;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cell rnd_cell();
        t_cell c;
        c.px = rnd_word(); c.py = rnd_word(); c.pz = rnd_word();
        c.vx = rnd_word(); c.vy = rnd_word(); c.vz = rnd_word();
        c.rho = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
        c.vol = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
        if ($urandom_range(0, 15) == 0) begin
            // cell sitting on the centre
            c.px = cen_x; c.py = cen_y; c.pz = cen_z;
        end
        return c;
    endfunction

    // output side: random stall per transfer, check at the rising edge
    initial begin
        t_src e;
        src_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            src_ch.ready = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10)) @(negedge i_clk);
            src_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!src_ch.valid) @(posedge i_clk);
            if (pending_src.size() == 0) begin
                report("unexpected transfer", src_ch.mom_source_x, 32'h0);
            end else begin
                e = pending_src.pop_front();
                if (src_ch.mom_source_x !== e.mx)
                    report("mom_source_x", src_ch.mom_source_x, e.mx);
                if (src_ch.mom_source_y !== e.my)
                    report("mom_source_y", src_ch.mom_source_y, e.my);
                if (src_ch.mom_source_z !== e.mz)
                    report("mom_source_z", src_ch.mom_source_z, e.mz);
                if (src_ch.energy_source !== e.en)
                    report("energy_source", src_ch.energy_source, e.en);
                if (src_ch.zero_distance !== e.zd)
                    report("zero_distance", 32'(src_ch.zero_distance), 32'(e.zd));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_cell c;
        t_src z, zd;
        cell_ch.valid = 1'b0;
        cell_ch.pos_x = '0; cell_ch.pos_y = '0; cell_ch.pos_z = '0;
        cell_ch.density = '0; cell_ch.cell_volume = '0;
        cell_ch.vel_x = '0; cell_ch.vel_y = '0; cell_ch.vel_z = '0;
        cen_x = 0; cen_y = 0; cen_z = 0; coeff = 0;
        z = '{default: '0};
        zd = z; zd.zd = 1'b1;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows, with reset registers: coefficient zero gives zero sources
        rows.push_back('{'{0, 0, 0, 32'hFFFF_FFFF, 5, 5, 5, 32'hFFFF_FFFF}, 1'b1, zd});
        rows.push_back('{'{1 << FB, 0, 0, 1 << FB, 1 << FB, 0, 0, 1 << FB}, 1'b1, z});
        rows.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                           32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF}, 1'b1, z});
        foreach (rows[i]) send_cell(rows[i].c, rows[i].known, rows[i].r);
        drain();

        // unit coefficient, centre at origin, then extremes of the centre
        set_centre(0, 0, 0, 1 << FB);
        rows.delete();
        rows.push_back('{'{1 << FB, 0, 0, 1 << FB, 1 << FB, 0, 0, 1 << FB}, 1'b0, z});
        rows.push_back('{'{0, -(2 << FB), 0, 1 << FB, 0, 1 << FB, 0, 1 << FB}, 1'b0, z});
        rows.push_back('{'{0, 0, 3 << FB, 4 << FB, 0, 0, -(1 << FB), 2 << FB}, 1'b0, z});
        rows.push_back('{'{1, 1, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 7,
                           32'hFFFF_FFFF}, 1'b0, z});
        rows.push_back('{'{1, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF},
                         1'b0, z});
        rows.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 1, 1, 1},
                         1'b0, z});
        rows.push_back('{'{0, 0, 0, 1, 1, 1, 1, 1}, 1'b1, zd});
        rows.push_back('{'{-1, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF}, 1'b1, z});
        foreach (rows[i]) send_cell(rows[i].c, rows[i].known, rows[i].r);
        drain();
        set_centre(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        rows.delete();
        rows.push_back('{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
                         1'b0, z});
        rows.push_back('{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 3, 3, 3, 3, 3},
                         1'b1, zd});
        rows.push_back('{'{32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                           32'h8000_0000, 0, 0, 32'hFFFF_FFFF}, 1'b0, z});
        foreach (rows[i]) send_cell(rows[i].c, rows[i].known, rows[i].r);
        drain();

        // random phases, new settings between them
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_centre(0, 0, 0, 1 << FB);
                1: set_centre($urandom, $urandom, $urandom, $urandom);
                2: set_centre(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1);
                3: set_centre($urandom_range(0, 16) << FB, 0, -(5 << FB),
                              $urandom_range(1, 1 << 24));
                default: set_centre($urandom, $urandom, $urandom, 32'hFFFF_FFFF);
            endcase
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                c = rnd_cell();
                send_cell(c, 1'b0, z);
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
